### design/tls_pkg.sv
package tls_pkg;

    localparam int COUNT_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_W      = 8;
    localparam int WIN_W      = 3;
    localparam int LIGHT_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAIN_GREEN_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_RED_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_WINDOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CAR_WINDOWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_TIME       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PED_CLEAR_TIME  = 3'd6;

    localparam logic [LEN_W-1:0] RST_MAIN_GREEN_MIN  = 8'd75;
    localparam logic [LEN_W-1:0] RST_YELLOW_TIME     = 8'd30;
    localparam logic [LEN_W-1:0] RST_ALL_RED_TIME    = 8'd5;
    localparam logic [LEN_W-1:0] RST_CAR_WINDOW      = 8'd25;
    localparam logic [WIN_W-1:0] RST_MAX_CAR_WINDOWS = 3'd3;
    localparam logic [LEN_W-1:0] RST_WALK_TIME       = 8'd100;
    localparam logic [LEN_W-1:0] RST_PED_CLEAR_TIME  = 8'd50;

    localparam logic [LIGHT_W-1:0] LIGHT_GREEN  = 2'd0;
    localparam logic [LIGHT_W-1:0] LIGHT_YELLOW = 2'd1;
    localparam logic [LIGHT_W-1:0] LIGHT_RED    = 2'd2;

    localparam logic [WIN_W-1:0] WIN_SAT = 3'd7;

    typedef enum logic [7:0] {
        PH_MAIN_GREEN  = 8'b0000_0001,
        PH_MAIN_YELLOW = 8'b0000_0010,
        PH_RED_A       = 8'b0000_0100,
        PH_CAR         = 8'b0000_1000,
        PH_WALK        = 8'b0001_0000,
        PH_PED_CLEAR   = 8'b0010_0000,
        PH_SIDE_YELLOW = 8'b0100_0000,
        PH_RED_B       = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_CAR  = 2'd1,
        REQ_PED  = 2'd2
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0] main_green_min;
        logic [LEN_W-1:0] yellow_time;
        logic [LEN_W-1:0] all_red_time;
        logic [LEN_W-1:0] car_window;
        logic [WIN_W-1:0] max_car_windows;
        logic [LEN_W-1:0] walk_time;
        logic [LEN_W-1:0] ped_clear_time;
    } cfg_t;

    typedef struct packed {
        logic [LIGHT_W-1:0] main_light;
        logic [LIGHT_W-1:0] side_light;
        logic               ped_walk;
    } result_t;

endpackage

### design/tls_cfg.sv
module tls_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_data,
    output tls_pkg::cfg_t                  cfg
);
    import tls_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.main_green_min  <= RST_MAIN_GREEN_MIN;
            cfg_reg.yellow_time     <= RST_YELLOW_TIME;
            cfg_reg.all_red_time    <= RST_ALL_RED_TIME;
            cfg_reg.car_window      <= RST_CAR_WINDOW;
            cfg_reg.max_car_windows <= RST_MAX_CAR_WINDOWS;
            cfg_reg.walk_time       <= RST_WALK_TIME;
            cfg_reg.ped_clear_time  <= RST_PED_CLEAR_TIME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAIN_GREEN_MIN:  cfg_reg.main_green_min  <= cfg_data;
                REG_YELLOW_TIME:     cfg_reg.yellow_time     <= cfg_data;
                REG_ALL_RED_TIME:    cfg_reg.all_red_time    <= cfg_data;
                REG_CAR_WINDOW:      cfg_reg.car_window      <= cfg_data;
                REG_MAX_CAR_WINDOWS: cfg_reg.max_car_windows <= cfg_data[WIN_W-1:0];
                REG_WALK_TIME:       cfg_reg.walk_time       <= cfg_data;
                REG_PED_CLEAR_TIME:  cfg_reg.ped_clear_time  <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/tls_seq.sv
module tls_seq #(
    parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             car,
    input  logic             ped,
    input  tls_pkg::cfg_t    cfg,
    output tls_pkg::result_t res
);
    import tls_pkg::*;

    localparam int CW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] ticks_reg, ticks_next;
    req_t                  req_reg, req_next;
    logic                  ext_reg, ext_next;
    logic [WIN_W-1:0]      win_reg, win_next;

    logic [COUNT_BITS-1:0] ticks_inc;
    logic [LEN_W-1:0]      len;
    logic [CW-1:0]         lim;
    logic                  done;
    logic [WIN_W-1:0]      win_inc;
    logic                  ext_eff;

    always_comb
    begin
        unique case (phase_reg) inside
            PH_MAIN_GREEN:                  len = cfg.main_green_min;
            PH_MAIN_YELLOW, PH_SIDE_YELLOW: len = cfg.yellow_time;
            PH_CAR:                         len = cfg.car_window;
            PH_WALK:                        len = cfg.walk_time;
            PH_PED_CLEAR:                   len = cfg.ped_clear_time;
            default:                        len = cfg.all_red_time;
        endcase
    end

    always_comb
    begin
        ticks_inc = (ticks_reg == CNT_MAX) ? ticks_reg : ticks_reg + 1'b1;
        lim       = (CW'(len) > CW'(CNT_MAX)) ? CW'(CNT_MAX) : CW'(len);
        done      = CW'(ticks_inc) >= lim;
        win_inc   = (win_reg < WIN_SAT) ? win_reg + 1'b1 : win_reg;
        ext_eff   = ext_reg | (car & ~ped);
    end

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_inc;
        req_next   = req_reg;
        ext_next   = ext_reg;
        win_next   = win_reg;
        res.main_light = LIGHT_RED;
        res.side_light = LIGHT_RED;
        res.ped_walk   = 1'b0;
        unique case (phase_reg)
            PH_MAIN_GREEN:
            begin
                res.main_light = LIGHT_GREEN;
                if (req_reg == REQ_NONE && (car || ped))
                begin
                    req_next = ped ? REQ_PED : REQ_CAR;
                end
                if (done && req_next != REQ_NONE)
                begin
                    phase_next = PH_MAIN_YELLOW;
                    ticks_next = '0;
                end
            end
            PH_MAIN_YELLOW:
            begin
                res.main_light = LIGHT_YELLOW;
                if (done)
                begin
                    phase_next = PH_RED_A;
                    ticks_next = '0;
                end
            end
            PH_RED_A:
            begin
                if (done)
                begin
                    ext_next   = 1'b0;
                    win_next   = '0;
                    phase_next = (req_reg == REQ_CAR) ? PH_CAR : PH_WALK;
                    ticks_next = '0;
                end
            end
            PH_CAR:
            begin
                res.side_light = LIGHT_GREEN;
                ext_next       = ext_eff;
                if (done)
                begin
                    win_next   = win_inc;
                    ticks_next = '0;
                    if (ext_eff && win_inc < cfg.max_car_windows)
                    begin
                        ext_next   = 1'b0;
                        phase_next = PH_CAR;
                    end
                    else
                    begin
                        phase_next = PH_SIDE_YELLOW;
                    end
                end
            end
            PH_WALK:
            begin
                res.side_light = LIGHT_GREEN;
                res.ped_walk   = 1'b1;
                if (done)
                begin
                    phase_next = PH_PED_CLEAR;
                    ticks_next = '0;
                end
            end
            PH_PED_CLEAR:
            begin
                res.side_light = LIGHT_GREEN;
                if (done)
                begin
                    phase_next = PH_SIDE_YELLOW;
                    ticks_next = '0;
                end
            end
            PH_SIDE_YELLOW:
            begin
                res.side_light = LIGHT_YELLOW;
                if (done)
                begin
                    phase_next = PH_RED_B;
                    ticks_next = '0;
                end
            end
            PH_RED_B:
            begin
                if (done)
                begin
                    req_next   = REQ_NONE;
                    ext_next   = 1'b0;
                    win_next   = '0;
                    phase_next = PH_MAIN_GREEN;
                    ticks_next = '0;
                end
            end
            default:
            begin
                req_next   = REQ_NONE;
                ext_next   = 1'b0;
                win_next   = '0;
                phase_next = PH_MAIN_GREEN;
                ticks_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAIN_GREEN;
            ticks_reg <= '0;
            req_reg   <= REQ_NONE;
            ext_reg   <= 1'b0;
            win_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            req_reg   <= req_next;
            ext_reg   <= ext_next;
            win_reg   <= win_next;
        end
    end

    a_phase_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(ticks_reg))
        else $error("Sequencer state moved without a tick.");

    a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_MAIN_GREEN |-> req_reg != REQ_NONE)
        else $error("Left main green without a latched request.");

    a_windows_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MAIN_GREEN || phase_reg == PH_MAIN_YELLOW || phase_reg == PH_RED_A
         || phase_reg == PH_WALK || phase_reg == PH_PED_CLEAR) |-> win_reg == '0)
        else $error("Window count not cleared outside the car sequence.");

endmodule

### design/traffic_light_sequencer_unit.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid, in_stall  car_button, ped_button
// result    out        out_valid, out_stall main_light, side_light, ped_walk
// config    in         cfg_we              cfg_index, cfg_data
//
// One tick per cycle unless stalled; it passes the input register and then the result register.
// The input register and the result register form a two-stage pipe around the sequencer.
// Reset brings the sequencer to main green, no request latched, and config registers to defaults.
// A stalled result holds the pipe, and in_stall rises only while the input register is full.
module traffic_light_sequencer_unit #(
    parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           car_button,
    input  logic                           ped_button,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tls_pkg::LIGHT_W-1:0]    main_light,
    output logic [tls_pkg::LIGHT_W-1:0]    side_light,
    output logic                           ped_walk,
    input  logic                           cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tls_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t result_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    car_reg;
    logic    ped_reg;
    logic    advance;
    logic    in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_take  = in_valid && !in_stall;
    assign in_stall = in_valid_reg && !advance;

    tls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tls_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .car   (car_reg),
        .ped   (ped_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            car_reg <= car_button;
            ped_reg <= ped_button;
        end
        if (advance)
        begin
            result_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign main_light = result_reg.main_light;
    assign side_light = result_reg.side_light;
    assign ped_walk   = result_reg.ped_walk;

    a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("Input stalled while the pipe could move.");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !in_valid_reg |=> !out_valid_reg)
        else $error("Result shown again after its transfer.");

    a_walk_safe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.ped_walk |->
            result_reg.side_light == LIGHT_GREEN && result_reg.main_light == LIGHT_RED)
        else $error("Walk shown without side green and main red.");

endmodule

### verif/tb_traffic_light_sequencer_unit.sv
`timescale 1ns / 100ps

module tb_traffic_light_sequencer_unit;

    import tls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    class signal_scoreboard;
        cfg_t                      timing;
        phase_t                    phase;
        logic [COUNT_BITS_DEF-1:0] ticks;
        req_t                      request;
        bit                        extended;
        logic [WIN_W-1:0]          windows;
        result_t                   expected_signals[$];
        int                        mismatches;

        function new();
            timing.main_green_min  = RST_MAIN_GREEN_MIN;
            timing.yellow_time     = RST_YELLOW_TIME;
            timing.all_red_time    = RST_ALL_RED_TIME;
            timing.car_window      = RST_CAR_WINDOW;
            timing.max_car_windows = RST_MAX_CAR_WINDOWS;
            timing.walk_time       = RST_WALK_TIME;
            timing.ped_clear_time  = RST_PED_CLEAR_TIME;
            phase      = PH_MAIN_GREEN;
            ticks      = '0;
            request    = REQ_NONE;
            extended   = 1'b0;
            windows    = '0;
            mismatches = 0;
        endfunction

        function void write_timing(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_MAIN_GREEN_MIN:  timing.main_green_min = value;
                REG_YELLOW_TIME:     timing.yellow_time = value;
                REG_ALL_RED_TIME:    timing.all_red_time = value;
                REG_CAR_WINDOW:      timing.car_window = value;
                REG_MAX_CAR_WINDOWS: timing.max_car_windows = value[WIN_W-1:0];
                REG_WALK_TIME:       timing.walk_time = value;
                REG_PED_CLEAR_TIME:  timing.ped_clear_time = value;
                default:             ;
            endcase
        endfunction

        // The phase counter saturates, so a long main green never wraps around.
        function bit count_done(logic [LEN_W-1:0] len);
            if (ticks != '1)
                ticks++;
            return ticks >= len;
        endfunction

        function void enter(phase_t next);
            phase = next;
            ticks = '0;
        endfunction

        function void note_tick(logic car, logic ped);
            result_t shown;
            case (phase)
                PH_MAIN_GREEN:  shown.main_light = LIGHT_GREEN;
                PH_MAIN_YELLOW: shown.main_light = LIGHT_YELLOW;
                default:        shown.main_light = LIGHT_RED;
            endcase
            case (phase)
                PH_CAR, PH_WALK, PH_PED_CLEAR: shown.side_light = LIGHT_GREEN;
                PH_SIDE_YELLOW:                shown.side_light = LIGHT_YELLOW;
                default:                       shown.side_light = LIGHT_RED;
            endcase
            shown.ped_walk = (phase == PH_WALK);
            expected_signals.push_back(shown);

            case (phase)
                PH_MAIN_GREEN:
                begin
                    if (request == REQ_NONE && (car || ped))
                    begin
                        if (ped)
                            request = REQ_PED;
                        else
                            request = REQ_CAR;
                    end
                    if (count_done(timing.main_green_min) && request != REQ_NONE)
                        enter(PH_MAIN_YELLOW);
                end
                PH_MAIN_YELLOW:
                begin
                    if (count_done(timing.yellow_time))
                        enter(PH_RED_A);
                end
                PH_RED_A:
                begin
                    if (count_done(timing.all_red_time))
                    begin
                        extended = 1'b0;
                        windows  = '0;
                        if (request == REQ_CAR)
                            enter(PH_CAR);
                        else
                            enter(PH_WALK);
                    end
                end
                PH_CAR:
                begin
                    if (car && !ped)
                        extended = 1'b1;
                    if (count_done(timing.car_window))
                    begin
                        if (windows != WIN_SAT)
                            windows++;
                        if (extended && windows < timing.max_car_windows)
                        begin
                            extended = 1'b0;
                            enter(PH_CAR);
                        end
                        else
                        begin
                            enter(PH_SIDE_YELLOW);
                        end
                    end
                end
                PH_WALK:
                begin
                    if (count_done(timing.walk_time))
                        enter(PH_PED_CLEAR);
                end
                PH_PED_CLEAR:
                begin
                    if (count_done(timing.ped_clear_time))
                        enter(PH_SIDE_YELLOW);
                end
                PH_SIDE_YELLOW:
                begin
                    if (count_done(timing.yellow_time))
                        enter(PH_RED_B);
                end
                default:
                begin
                    if (count_done(timing.all_red_time))
                    begin
                        request  = REQ_NONE;
                        extended = 1'b0;
                        windows  = '0;
                        enter(PH_MAIN_GREEN);
                    end
                end
            endcase
        endfunction

        function void check_signals(logic [LIGHT_W-1:0] main_seen, logic [LIGHT_W-1:0] side_seen,
                                    logic walk_seen);
            result_t want;
            if (expected_signals.size() == 0)
            begin
                $error("unexpected result transfer: main_light %0d side_light %0d ped_walk %0d",
                       main_seen, side_seen, walk_seen);
                mismatches++;
                return;
            end
            want = expected_signals.pop_front();
            if (main_seen !== want.main_light)
            begin
                $error("main_light: expected %0d, got %0d", want.main_light, main_seen);
                mismatches++;
            end
            if (side_seen !== want.side_light)
            begin
                $error("side_light: expected %0d, got %0d", want.side_light, side_seen);
                mismatches++;
            end
            if (walk_seen !== want.ped_walk)
            begin
                $error("ped_walk: expected %0d, got %0d", want.ped_walk, walk_seen);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  car_button;
    logic                  ped_button;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [LIGHT_W-1:0]    main_light;
    logic [LIGHT_W-1:0]    side_light;
    logic                  ped_walk;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    signal_scoreboard board;
    bit               idle_on = 1'b1;
    int               stall_left = 0;

    traffic_light_sequencer_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .car_button (car_button),
        .ped_button (ped_button),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .main_light (main_light),
        .side_light (side_light),
        .ped_walk   (ped_walk),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (idle_on && stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(1, 13) - 1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_signals(main_light, side_light, ped_walk);
    end

    task automatic send_tick(input logic car, input logic ped);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid   = 1'b1;
        car_button = car;
        ped_button = ped;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_tick(car, ped);
        @(negedge clk);
    endtask

    task automatic send_random_ticks(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            send_tick((pick >= 4 && pick <= 6) || pick == 9, pick >= 7);
        end
    endtask

    task automatic drain_signals();
        in_valid = 1'b0;
        while (board.expected_signals.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        board.write_timing(index, value);
    endtask

    task automatic load_timing(input logic [7:0] green_min, input logic [7:0] yellow,
                               input logic [7:0] red, input logic [7:0] window,
                               input logic [7:0] window_limit, input logic [7:0] walk,
                               input logic [7:0] clear);
        drain_signals();
        write_reg(REG_MAIN_GREEN_MIN, green_min);
        write_reg(REG_YELLOW_TIME, yellow);
        write_reg(REG_ALL_RED_TIME, red);
        write_reg(REG_CAR_WINDOW, window);
        write_reg(REG_MAX_CAR_WINDOWS, window_limit);
        write_reg(REG_WALK_TIME, walk);
        write_reg(REG_PED_CLEAR_TIME, clear);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        car_button = 1'b0;
        ped_button = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        board      = new();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Both buttons on one tick latch a pedestrian request.
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);

        // Zero lengths act as one tick and a zero window limit as one window.
        load_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'hF8, 8'd0, 8'd0);
        write_reg(REG_UNUSED, 8'hFF);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);

        // A car press extends the window; a press of both buttons does not.
        drain_signals();
        write_reg(REG_MAX_CAR_WINDOWS, 8'h07);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);

        // A long empty main green runs the phase counter into saturation.
        load_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd7, 8'd255, 8'd255);
        repeat (270) send_tick(1'b0, 1'b0);
        send_random_ticks(40);

        load_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd7, 8'd1, 8'd1);
        send_random_ticks(30);

        repeat (3)
        begin
            load_timing(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                        8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                        8'($urandom_range(0, 7)), 8'($urandom_range(0, 6)),
                        8'($urandom_range(0, 6)));
            send_random_ticks(20);
        end

        idle_on = 1'b0;
        load_timing(8'd2, 8'd3, 8'd1, 8'd4, 8'd2, 8'd3, 8'd2);
        send_random_ticks(30);

        drain_signals();
        repeat (4) @(negedge clk);
        if (board.mismatches == 0 && board.expected_signals.size() == 0)
            $display("traffic_light_sequencer_unit verification clean");
        else
            $display("traffic_light_sequencer_unit verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("traffic_light_sequencer_unit verification failed");
        $finish;
    end

endmodule
